FILE: hw/rtl/ubds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubds_pkg: shared types and constants of the baud divisor search
// Status codes, field widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package ubds_pkg;

    localparam int KhzW   = 16;
    localparam int BaudW  = 24;
    localparam int ClkW   = 26;   // khz*1000 < 2^26
    localparam int OsrW   = 6;
    localparam int SbrW   = 13;
    localparam int StW    = 2;

    localparam logic [KhzW-1:0] ClkMinKhz = 16'd32;
    localparam logic [KhzW-1:0] ClkMaxKhz = 16'd50000;
    localparam logic [OsrW-1:0] OsrFirst  = 6'd4;
    localparam logic [OsrW-1:0] OsrLast   = 6'd32;
    localparam logic [OsrW-1:0] EdgeLast  = 6'd8;

    localparam logic [StW-1:0] ST_OK        = 2'd0;
    localparam logic [StW-1:0] ST_BAD_CLOCK = 2'd1;
    localparam logic [StW-1:0] ST_BAD_DEV   = 2'd2;
    localparam logic [StW-1:0] ST_ZERO_BAUD = 2'd3;

    localparam int FifoDepthDef = 2;

    // classified item handed from front to back
    typedef struct packed {
        logic             search;   // 1: run the ratio search
        logic [StW-1:0]   status;   // early status when no search
        logic [ClkW-1:0]  clk;
        logic [BaudW-1:0] baud;
    } ubds_cmd_t;

endpackage : ubds_pkg
`default_nettype wire

FILE: hw/rtl/ubds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubds_front: input classification
// Checks the clock range and zero baud, scales the clock to Hz.
// ----------------------------------------------------------------------------
module ubds_front
    import ubds_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [KhzW-1:0]  s_clock_khz,
    input  wire logic [BaudW-1:0] s_wanted_baud,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output ubds_cmd_t             cmd
);
    logic      valid_reg;
    ubds_cmd_t cmd_reg;
    ubds_cmd_t cmd_next;

    always_comb begin
        cmd_next        = '0;
        cmd_next.clk    = ClkW'({10'd0, s_clock_khz} * 26'd1000);
        cmd_next.baud   = s_wanted_baud;
        if (s_clock_khz < ClkMinKhz || s_clock_khz > ClkMaxKhz) begin
            cmd_next.status = ST_BAD_CLOCK;
        end else if (s_wanted_baud == '0) begin
            cmd_next.status = ST_ZERO_BAUD;
        end else begin
            cmd_next.search = 1'b1;
            cmd_next.status = ST_OK;
        end
    end

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule : ubds_front
`default_nettype wire

FILE: hw/rtl/ubds_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubds_fifo: command queue
// Small register queue between classification and search.
// ----------------------------------------------------------------------------
module ubds_fifo
    import ubds_pkg::*;
#(
    parameter int Depth = FifoDepthDef
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ubds_cmd_t in_cmd,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ubds_cmd_t      out_cmd
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    ubds_cmd_t          mem [Depth];
    logic [AW-1:0]      wr_reg, rd_reg;
    logic [AW:0]        cnt_reg;
    logic               push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(Depth));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            mem[wr_reg] <= in_cmd;
        end
    end
endmodule : ubds_fifo
`default_nettype wire

FILE: hw/rtl/ubds_divu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubds_divu: radix-2 unsigned divider
// Restoring divide of a 26-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubds_divu
    import ubds_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [ClkW-1:0]  dividend,
    input  wire logic [31:0]      divisor,
    output logic                  done,
    output logic [ClkW-1:0]       quotient
);
    localparam int CW = $clog2(ClkW + 1);

    logic [ClkW-1:0] q_reg;
    logic [32:0]     r_reg;
    logic [31:0]     d_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;
    logic [32:0]     shifted, diff;

    assign shifted  = {r_reg[31:0], q_reg[ClkW-1]};
    assign diff     = shifted - {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ClkW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                r_reg <= diff;
                q_reg <= {q_reg[ClkW-2:0], 1'b1};
            end else begin
                r_reg <= shifted;
                q_reg <= {q_reg[ClkW-2:0], 1'b0};
            end
        end
    end
endmodule : ubds_divu
`default_nettype wire

FILE: hw/rtl/ubds_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubds_back: ratio search engine
// Walks ratios 4..32 with a shared divider, keeps the best, holds result.
// ----------------------------------------------------------------------------
module ubds_back
    import ubds_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire ubds_cmd_t       cmd,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [OsrW-1:0]      m_oversample_ratio,
    output logic [SbrW-1:0]      m_divisor,
    output logic                 m_both_edge,
    output logic [1:0]           m_status
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_CMP, S_THR, S_OUT
    } state_t;

    state_t          state_reg;
    logic [ClkW-1:0] clk_reg;
    logic [BaudW-1:0] baud_reg;
    logic [OsrW-1:0] osr_reg, best_osr_reg;
    logic [ClkW-1:0] sbr_reg, best_sbr_reg, got_reg;
    logic [BaudW:0]  best_diff_reg;
    logic            found_reg;
    logic [31:0]     prod_reg;
    logic            div_start_reg;
    logic            div_done;
    logic [ClkW-1:0] quot;
    logic [BaudW:0]  diff;
    logic [55:0]     recip_prod;
    logic [17:0]     baud_div100;
    logic [BaudW:0]  thr;
    logic [BaudW:0]  thr_reg;
    logic            out_v_reg;
    logic [OsrW-1:0] o_osr_reg;
    logic [SbrW-1:0] o_sbr_reg;
    logic            o_edge_reg;
    logic [1:0]      o_st_reg;

    ubds_divu u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (clk_reg),
        .divisor  (prod_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign diff = ({1'b0, got_reg[BaudW-1:0]} > {1'b0, baud_reg} || got_reg[ClkW-1:BaudW] != '0)
                ? (BaudW+1)'(got_reg - ClkW'(baud_reg))
                : (BaudW+1)'(baud_reg - got_reg[BaudW-1:0]);
    // baud/100 by reciprocal multiply (exact for any 24-bit baud), times 3
    assign recip_prod  = {32'd0, baud_reg} * 56'h51EB851F;
    assign baud_div100 = recip_prod[54:37];
    assign thr         = {6'd0, baud_div100, 1'b0} + {7'd0, baud_div100};

    assign cmd_ready          = (state_reg == S_IDLE) && (!out_v_reg || m_ready);
    assign m_valid            = out_v_reg;
    assign m_oversample_ratio = o_osr_reg;
    assign m_divisor          = o_sbr_reg;
    assign m_both_edge        = o_edge_reg;
    assign m_status           = o_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_v_reg     <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        if (cmd.search) begin
                            clk_reg   <= cmd.clk;
                            baud_reg  <= cmd.baud;
                            osr_reg   <= OsrFirst;
                            found_reg <= 1'b0;
                            state_reg <= S_MUL1;
                        end else begin
                            out_v_reg  <= 1'b1;
                            o_osr_reg  <= '0;
                            o_sbr_reg  <= '0;
                            o_edge_reg <= 1'b0;
                            o_st_reg   <= cmd.status;
                        end
                    end
                end
                S_MUL1: begin
                    prod_reg      <= {8'd0, baud_reg} * {26'd0, osr_reg};
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_done) begin
                        sbr_reg   <= quot;
                        state_reg <= (quot == '0) ? S_CMP : S_MUL2;
                    end
                end
                S_MUL2: begin
                    prod_reg      <= 32'(sbr_reg * osr_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_done) begin
                        got_reg   <= quot;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (sbr_reg != '0 && (!found_reg || diff <= best_diff_reg)) begin
                        found_reg     <= 1'b1;
                        best_diff_reg <= diff;
                        best_osr_reg  <= osr_reg;
                        best_sbr_reg  <= sbr_reg;
                    end
                    if (osr_reg == OsrLast) begin
                        thr_reg   <= thr;
                        state_reg <= S_THR;
                    end else begin
                        osr_reg   <= osr_reg + 1'b1;
                        state_reg <= S_MUL1;
                    end
                end
                S_THR: begin
                    if (!out_v_reg || m_ready) begin
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                        if (!found_reg || best_diff_reg >= thr_reg) begin
                            o_osr_reg  <= '0;
                            o_sbr_reg  <= '0;
                            o_edge_reg <= 1'b0;
                            o_st_reg   <= ST_BAD_DEV;
                        end else begin
                            o_osr_reg  <= best_osr_reg;
                            o_sbr_reg  <= best_sbr_reg[SbrW-1:0];
                            o_edge_reg <= (best_osr_reg <= EdgeLast);
                            o_st_reg   <= ST_OK;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule : ubds_back
`default_nettype wire

FILE: hw/rtl/uart_baud_divisor_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_baud_divisor_search: UART oversampling ratio and divisor selection
//
// Input item (s_valid/s_ready): source clock in kHz and wanted baud.
// Result item (m_valid/m_ready): ratio, 13-bit divisor, both-edge flag,
// status (ok, clock out of range, deviation >= 3 %, zero baud).
// The front registers and classifies each item and pushes it into a
// small queue; the back runs the search over ratios 4..32 with one
// shared radix-2 divider (up to two divides per ratio; the second is
// skipped when the first quotient is zero). Rejected items skip the
// search. The back's single divider sets the rate.
// Reset (aresetn low, synchronous) empties the queue and drops any item
// in flight. A stalled receiver holds the result in the output register;
// the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search
    import ubds_pkg::*;
#(
    parameter int FifoDepth = FifoDepthDef
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [15:0]      s_clock_khz,
    input  wire logic [23:0]      s_wanted_baud,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [5:0]            m_oversample_ratio,
    output logic [12:0]           m_divisor,
    output logic                  m_both_edge,
    output logic [1:0]            m_status
);
    logic      f_valid, f_ready, q_valid, q_ready;
    ubds_cmd_t f_cmd, q_cmd;

    ubds_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_clock_khz, .s_wanted_baud,
        .cmd_valid (f_valid), .cmd_ready (f_ready), .cmd (f_cmd)
    );

    ubds_fifo #(.Depth(FifoDepth)) u_fifo (
        .aclk, .aresetn,
        .in_valid (f_valid), .in_ready (f_ready), .in_cmd (f_cmd),
        .out_valid (q_valid), .out_ready (q_ready), .out_cmd (q_cmd)
    );

    ubds_back u_back (
        .aclk, .aresetn,
        .cmd_valid (q_valid), .cmd_ready (q_ready), .cmd (q_cmd),
        .m_valid, .m_ready, .m_oversample_ratio, .m_divisor,
        .m_both_edge, .m_status
    );

    a_ok_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_oversample_ratio >= OsrFirst &&
        m_oversample_ratio <= OsrLast)
        else $error("ok result with ratio out of range");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_oversample_ratio == '0 && m_divisor == '0)
        else $error("error result carries nonzero fields");
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_both_edge == (m_status == ST_OK && m_oversample_ratio <= EdgeLast))
        else $error("both_edge flag mismatch");
endmodule : uart_baud_divisor_search
`default_nettype wire
